>>> sv/xbtm_pkg.sv
// Shared types, sizes and codes for the XOR binary trie multiset.
// Used by xbtm_ctrl, xor_binary_trie_multiset_core and xbtm_chk.
`default_nettype none

package xbtm_pkg;

  // Trie geometry and node count width
  localparam int VALUE_BITS = 8;
  localparam int COUNT_BITS = 16;
  localparam int NODE_W     = VALUE_BITS + 1;
  localparam int NODE_DEPTH = 2 ** NODE_W;

  // Port field widths
  localparam int OPC_W  = 3;
  localparam int VAL_W  = 8;
  localparam int AMT_W  = 16;
  localparam int RCNT_W = 16;
  localparam int ST_W   = 3;

  // Width that holds any count or amount plus one carry bit
  localparam int WIDE_W = ((COUNT_BITS > AMT_W) ? COUNT_BITS : AMT_W) + 1;

  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
  localparam logic [NODE_W-1:0]     ROOT    = NODE_W'(1);

  // Operation codes
  localparam logic [OPC_W-1:0] OP_INSERT = 3'd0;
  localparam logic [OPC_W-1:0] OP_ERASE  = 3'd1;
  localparam logic [OPC_W-1:0] OP_COUNT  = 3'd2;
  localparam logic [OPC_W-1:0] OP_MAX    = 3'd3;
  localparam logic [OPC_W-1:0] OP_MIN    = 3'd4;
  localparam logic [OPC_W-1:0] OP_KTH    = 3'd5;
  localparam logic [OPC_W-1:0] OP_XOR    = 3'd6;
  localparam logic [OPC_W-1:0] OP_SIZE   = 3'd7;

  // Status codes
  localparam logic [ST_W-1:0] ST_OK        = 3'd0;
  localparam logic [ST_W-1:0] ST_EMPTY     = 3'd1;
  localparam logic [ST_W-1:0] ST_BAD_RANK  = 3'd2;
  localparam logic [ST_W-1:0] ST_UNDERFLOW = 3'd3;
  localparam logic [ST_W-1:0] ST_OVERFLOW  = 3'd4;

  // Node count memory request from the sequencer
  typedef struct packed {
    logic                  we;
    logic [NODE_W-1:0]     waddr;
    logic [COUNT_BITS-1:0] wdata;
    logic                  re;
    logic [NODE_W-1:0]     raddr;
  } ram_req_t;

  // Child of a trie node: append one path bit
  function automatic logic [NODE_W-1:0] child_of(input logic [NODE_W-1:0] idx,
                                                 input logic b);
    child_of = {idx[NODE_W-2:0], b};
  endfunction

endpackage

`default_nettype wire

>>> sv/xor_binary_trie_multiset_core.sv
// XOR binary trie multiset: sequencer plus node count RAM, one item at a time.
// Each item goes from accept through START, a LEAF read for erase and count, a WALK down the
// trie for insert, erase, max, min and kth, and DONE, which waits for a free result beat; the
// core takes a new item only after the last has left DONE, and walks one level per cycle
// through the single read port of the RAM. Reset: root count and mask clear at once; then a
// pass over all 2^(VALUE_BITS+1) addresses (512) zeroes the RAM while in_ready stays low.
`default_nettype none

module xor_binary_trie_multiset_core (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [xbtm_pkg::OPC_W-1:0]  opcode,
  input  wire logic [xbtm_pkg::VAL_W-1:0]  value,
  input  wire logic [xbtm_pkg::AMT_W-1:0]  amount,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic      [xbtm_pkg::VAL_W-1:0]  result_value,
  output logic      [xbtm_pkg::RCNT_W-1:0] result_count,
  output logic      [xbtm_pkg::ST_W-1:0]   status
);

  xbtm_pkg::ram_req_t                  ram_req;
  logic [xbtm_pkg::COUNT_BITS-1:0]     rd_data;

  xbtm_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .opcode       (opcode),
    .value        (value),
    .amount       (amount),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .result_value (result_value),
    .result_count (result_count),
    .status       (status),
    .ram_req      (ram_req),
    .rd_data      (rd_data)
  );

  xbtm_ram #(
    .ADDR_W (xbtm_pkg::NODE_W),
    .DATA_W (xbtm_pkg::COUNT_BITS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (rd_data)
  );

endmodule

`default_nettype wire

>>> sv/xbtm_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port.
// Generic; no package dependency.
`default_nettype none

module xbtm_ram #(
  parameter int ADDR_W = 9,
  parameter int DATA_W = 16
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> sv/xbtm_ctrl.sv
// Operation sequencer: walks the trie one level a cycle against the node count RAM,
// holds the root count and XOR mask, and registers the result beat. Uses xbtm_pkg.
`default_nettype none

module xbtm_ctrl (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [xbtm_pkg::OPC_W-1:0]    opcode,
  input  wire logic [xbtm_pkg::VAL_W-1:0]    value,
  input  wire logic [xbtm_pkg::AMT_W-1:0]    amount,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic      [xbtm_pkg::VAL_W-1:0]    result_value,
  output logic      [xbtm_pkg::RCNT_W-1:0]   result_count,
  output logic      [xbtm_pkg::ST_W-1:0]     status,
  output xbtm_pkg::ram_req_t                 ram_req,
  input  wire logic [xbtm_pkg::COUNT_BITS-1:0] rd_data
);

  localparam int VB = xbtm_pkg::VALUE_BITS;
  localparam int CB = xbtm_pkg::COUNT_BITS;
  localparam int NW = xbtm_pkg::NODE_W;
  localparam int WW = xbtm_pkg::WIDE_W;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_START = 3'd2;
  localparam logic [2:0] S_LEAF  = 3'd3;
  localparam logic [2:0] S_WALK  = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]                      state, state_next;
  logic [xbtm_pkg::OPC_W-1:0]      op, op_next;
  logic [VB-1:0]                   stored_sh, stored_sh_next;
  logic [VB-1:0]                   mask_sh, mask_sh_next;
  logic [VB-1:0]                   xval, xval_next;
  logic [xbtm_pkg::AMT_W-1:0]      amt, amt_next;
  logic [CB-1:0]                   kcnt, kcnt_next;
  logic [CB-1:0]                   size, size_next;
  logic [VB-1:0]                   mask, mask_next;
  logic [NW-1:0]                   cur, cur_next;
  logic [VB-1:0]                   res, res_next;
  logic [CB-1:0]                   rcnt, rcnt_next;
  logic [xbtm_pkg::ST_W-1:0]       st, st_next;
  logic [NW-1:0]                   clr_addr, clr_addr_next;
  logic                            ov, ov_next;
  logic [xbtm_pkg::VAL_W-1:0]      o_val, o_val_next;
  logic [xbtm_pkg::RCNT_W-1:0]     o_cnt, o_cnt_next;
  logic [xbtm_pkg::ST_W-1:0]       o_st, o_st_next;

  // walk helpers
  logic [VB-1:0] sh_s, sh_m;
  logic [CB-1:0] amt_c;
  logic          flip;
  logic [NW-1:0] chosen;
  logic          pref;

  assign in_ready     = (state == S_IDLE);
  assign out_valid    = ov;
  assign result_value = o_val;
  assign result_count = o_cnt;
  assign status       = o_st;

  always_comb begin
    state_next     = state;
    op_next        = op;
    stored_sh_next = stored_sh;
    mask_sh_next   = mask_sh;
    xval_next      = xval;
    amt_next       = amt;
    kcnt_next      = kcnt;
    size_next      = size;
    mask_next      = mask;
    cur_next       = cur;
    res_next       = res;
    rcnt_next      = rcnt;
    st_next        = st;
    clr_addr_next  = clr_addr;
    ov_next        = ov;
    o_val_next     = o_val;
    o_cnt_next     = o_cnt;
    o_st_next      = o_st;
    ram_req        = '0;

    sh_s   = stored_sh << 1;
    sh_m   = mask_sh << 1;
    amt_c  = CB'(amt);
    flip   = (op == xbtm_pkg::OP_KTH) ? (rd_data < kcnt) : (rd_data == '0);
    chosen = cur ^ NW'(flip);
    pref   = sh_m[VB-1] ^ (op == xbtm_pkg::OP_MAX);

    if (ov && out_ready) begin
      ov_next = 1'b0;
    end

    case (state)
      S_CLEAR: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = clr_addr;
        ram_req.wdata = '0;
        clr_addr_next = clr_addr + NW'(1);
        if (clr_addr == '1) begin
          state_next = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_valid) begin
          op_next        = opcode;
          stored_sh_next = VB'(value) ^ mask;
          mask_sh_next   = mask;
          xval_next      = VB'(value);
          amt_next       = amount;
          res_next       = '0;
          rcnt_next      = '0;
          st_next        = xbtm_pkg::ST_OK;
          state_next     = S_START;
        end
      end

      S_START: begin
        case (op)
          xbtm_pkg::OP_INSERT: begin
            if ((WW'(size) + WW'(amt)) > WW'(xbtm_pkg::CNT_MAX)) begin
              st_next    = xbtm_pkg::ST_OVERFLOW;
              state_next = S_DONE;
            end else begin
              size_next     = size + amt_c;
              cur_next      = xbtm_pkg::child_of(xbtm_pkg::ROOT, stored_sh[VB-1]);
              ram_req.re    = 1'b1;
              ram_req.raddr = cur_next;
              state_next    = S_WALK;
            end
          end
          xbtm_pkg::OP_ERASE, xbtm_pkg::OP_COUNT: begin
            cur_next      = {1'b1, stored_sh};
            ram_req.re    = 1'b1;
            ram_req.raddr = cur_next;
            state_next    = S_LEAF;
          end
          xbtm_pkg::OP_MAX, xbtm_pkg::OP_MIN: begin
            if (size == '0) begin
              st_next    = xbtm_pkg::ST_EMPTY;
              state_next = S_DONE;
            end else begin
              cur_next      = xbtm_pkg::child_of(xbtm_pkg::ROOT,
                                mask_sh[VB-1] ^ (op == xbtm_pkg::OP_MAX));
              ram_req.re    = 1'b1;
              ram_req.raddr = cur_next;
              state_next    = S_WALK;
            end
          end
          xbtm_pkg::OP_KTH: begin
            if (amt == '0 || WW'(amt) > WW'(size)) begin
              st_next    = xbtm_pkg::ST_BAD_RANK;
              state_next = S_DONE;
            end else begin
              kcnt_next     = amt_c;
              cur_next      = xbtm_pkg::child_of(xbtm_pkg::ROOT, mask_sh[VB-1]);
              ram_req.re    = 1'b1;
              ram_req.raddr = cur_next;
              state_next    = S_WALK;
            end
          end
          xbtm_pkg::OP_XOR: begin
            // an empty set keeps its mask
            if (size != '0) begin
              mask_next = mask ^ xval;
            end
            state_next = S_DONE;
          end
          default: begin
            rcnt_next  = size;
            state_next = S_DONE;
          end
        endcase
      end

      S_LEAF: begin
        if (op == xbtm_pkg::OP_COUNT) begin
          rcnt_next  = rd_data;
          state_next = S_DONE;
        end else if (WW'(rd_data) < WW'(amt)) begin
          st_next    = xbtm_pkg::ST_UNDERFLOW;
          state_next = S_DONE;
        end else begin
          size_next     = size - amt_c;
          cur_next      = xbtm_pkg::child_of(xbtm_pkg::ROOT, stored_sh[VB-1]);
          ram_req.re    = 1'b1;
          ram_req.raddr = cur_next;
          state_next    = S_WALK;
        end
      end

      S_WALK: begin
        if (op == xbtm_pkg::OP_INSERT || op == xbtm_pkg::OP_ERASE) begin
          // write back this level, fetch the next one down
          ram_req.we    = 1'b1;
          ram_req.waddr = cur;
          ram_req.wdata = (op == xbtm_pkg::OP_INSERT) ? (rd_data + amt_c)
                                                      : (rd_data - amt_c);
          if (cur[NW-1]) begin
            state_next = S_DONE;
          end else begin
            stored_sh_next = sh_s;
            cur_next       = xbtm_pkg::child_of(cur, sh_s[VB-1]);
            ram_req.re     = 1'b1;
            ram_req.raddr  = cur_next;
          end
        end else begin
          // take the sibling when the preferred side is empty or too small
          if (op == xbtm_pkg::OP_KTH && flip) begin
            kcnt_next = kcnt - rd_data;
          end
          res_next = (res << 1) | VB'(chosen[0] ^ mask_sh[VB-1]);
          if (chosen[NW-1]) begin
            state_next = S_DONE;
          end else begin
            mask_sh_next  = sh_m;
            cur_next      = xbtm_pkg::child_of(chosen, pref);
            ram_req.re    = 1'b1;
            ram_req.raddr = cur_next;
          end
        end
      end

      S_DONE: begin
        if (!ov || out_ready) begin
          ov_next    = 1'b1;
          o_val_next = xbtm_pkg::VAL_W'(res);
          o_cnt_next = xbtm_pkg::RCNT_W'(rcnt);
          o_st_next  = st;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      ov       <= 1'b0;
      size     <= '0;
      mask     <= '0;
    end else begin
      state    <= state_next;
      clr_addr <= clr_addr_next;
      ov       <= ov_next;
      size     <= size_next;
      mask     <= mask_next;
    end
  end

  always_ff @(posedge clk) begin
    op        <= op_next;
    stored_sh <= stored_sh_next;
    mask_sh   <= mask_sh_next;
    xval      <= xval_next;
    amt       <= amt_next;
    kcnt      <= kcnt_next;
    cur       <= cur_next;
    res       <= res_next;
    rcnt      <= rcnt_next;
    st        <= st_next;
    o_val     <= o_val_next;
    o_cnt     <= o_cnt_next;
    o_st      <= o_st_next;
  end

endmodule

`default_nettype wire

>>> sv/xbtm_chk.sv
// Port-level checker for xor_binary_trie_multiset_core, attached by bind.
// Uses xbtm_pkg for status codes.
`default_nettype none

module xbtm_chk (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        in_valid,
  input wire logic                        in_ready,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic [xbtm_pkg::VAL_W-1:0]  result_value,
  input wire logic [xbtm_pkg::RCNT_W-1:0] result_count,
  input wire logic [xbtm_pkg::ST_W-1:0]   status
);

  logic in_beat;
  assign in_beat = in_valid && in_ready;

  // the clearing pass keeps the input closed after reset
  a_clear_closed: assert property (@(posedge clk) rst |=> !in_ready)
    else $error("input open during RAM clear");

  // one item at a time: no second beat straight after an accepted one
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_beat |=> !in_ready)
    else $error("input taken while an item is in work");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result_value)
      && $stable(result_count) && $stable(status))
    else $error("result beat changed while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == xbtm_pkg::ST_OK || status == xbtm_pkg::ST_EMPTY
      || status == xbtm_pkg::ST_BAD_RANK || status == xbtm_pkg::ST_UNDERFLOW
      || status == xbtm_pkg::ST_OVERFLOW))
    else $error("undefined status code");

  // a failed operation reports nothing else
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != xbtm_pkg::ST_OK |-> result_value == '0 && result_count == '0)
    else $error("non-zero result with error status");

endmodule

bind xor_binary_trie_multiset_core xbtm_chk u_chk (.*);

`default_nettype wire

>>> tb/xor_binary_trie_multiset_core_tb.sv
// Self-checking bench for xor_binary_trie_multiset_core: directed corner cases, then random traffic.
// Predicts each beat with its own trie of node counts and XOR mask; needs xbtm_pkg and the core RTL.
`timescale 1ns / 1ps

module xor_binary_trie_multiset_core_tb;

  localparam int CYCLE_CAP  = 400000;
  localparam int PRINT_CAP  = 100;
  localparam int DRAIN_TIME = 30;
  localparam int VB         = xbtm_pkg::VALUE_BITS;
  localparam int NW         = xbtm_pkg::NODE_W;

  typedef struct packed {
    logic [xbtm_pkg::VAL_W-1:0]  value;
    logic [xbtm_pkg::RCNT_W-1:0] count;
    logic [xbtm_pkg::ST_W-1:0]   status;
  } outcome_t;

  logic                        clk;
  logic                        rst       = 1'b1;
  logic                        in_valid  = 1'b0;
  logic                        in_ready;
  logic [xbtm_pkg::OPC_W-1:0]  opcode    = xbtm_pkg::OP_SIZE;
  logic [xbtm_pkg::VAL_W-1:0]  value     = '0;
  logic [xbtm_pkg::AMT_W-1:0]  amount    = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic [xbtm_pkg::VAL_W-1:0]  result_value;
  logic [xbtm_pkg::RCNT_W-1:0] result_count;
  logic [xbtm_pkg::ST_W-1:0]   status;

  // Predicted trie contents and whole-set mask
  logic [xbtm_pkg::COUNT_BITS-1:0] trie_cnt [xbtm_pkg::NODE_DEPTH];
  logic [VB-1:0]                   trie_mask;

  outcome_t    pending_q [$];
  outcome_t    due;
  int unsigned mismatches = 0;
  int unsigned cycle_cnt  = 0;
  int          burst_left = 0;
  int          stall_left = 0;
  int          stall_mode = 0;

  xor_binary_trie_multiset_core u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .opcode       (opcode),
    .value        (value),
    .amount       (amount),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .result_value (result_value),
    .result_count (result_count),
    .status       (status)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [NW-1:0] leaf_at(logic [xbtm_pkg::VAL_W-1:0] v);
    return {1'b1, v[VB-1:0] ^ trie_mask};
  endfunction

  function automatic void walk_add(logic [VB-1:0] stored, logic [xbtm_pkg::AMT_W-1:0] amt,
                                   bit sub);
    logic [NW-1:0] idx;
    idx = xbtm_pkg::ROOT;
    for (int lvl = 0; lvl <= VB; lvl++) begin
      if (sub)
        trie_cnt[idx] = xbtm_pkg::COUNT_BITS'(trie_cnt[idx] - amt);
      else
        trie_cnt[idx] = xbtm_pkg::COUNT_BITS'(trie_cnt[idx] + amt);
      if (lvl < VB)
        idx = xbtm_pkg::child_of(idx, stored[VB-1-lvl]);
    end
  endfunction

  function automatic logic [VB-1:0] extreme_of(bit want_high);
    logic [NW-1:0] idx;
    logic [NW-1:0] pick;
    logic          m;
    logic [VB-1:0] res;
    idx = xbtm_pkg::ROOT;
    res = '0;
    for (int b = VB - 1; b >= 0; b--) begin
      m    = trie_mask[b];
      pick = xbtm_pkg::child_of(idx, want_high ? !m : m);
      if (trie_cnt[pick] == '0)
        pick[0] = ~pick[0];
      res[b] = pick[0] ^ m;
      idx    = pick;
    end
    return res;
  endfunction

  function automatic logic [VB-1:0] rank_of(int unsigned k);
    logic [NW-1:0] idx;
    logic [NW-1:0] lo;
    logic [VB-1:0] res;
    idx = xbtm_pkg::ROOT;
    res = '0;
    for (int b = VB - 1; b >= 0; b--) begin
      lo = xbtm_pkg::child_of(idx, trie_mask[b]);
      if (32'(trie_cnt[lo]) >= k) begin
        idx = lo;
      end else begin
        k      = k - 32'(trie_cnt[lo]);
        res[b] = 1'b1;
        idx    = {lo[NW-1:1], ~lo[0]};
      end
    end
    return res;
  endfunction

  function automatic outcome_t apply_op(logic [xbtm_pkg::OPC_W-1:0] op,
                                        logic [xbtm_pkg::VAL_W-1:0] v,
                                        logic [xbtm_pkg::AMT_W-1:0] amt);
    outcome_t      o;
    logic [VB-1:0] stored;
    int unsigned   sz;
    o      = '0;
    stored = v[VB-1:0] ^ trie_mask;
    sz     = 32'(trie_cnt[xbtm_pkg::ROOT]);
    case (op)
      xbtm_pkg::OP_INSERT: begin
        if (sz + 32'(amt) > 32'(xbtm_pkg::CNT_MAX))
          o.status = xbtm_pkg::ST_OVERFLOW;
        else
          walk_add(stored, amt, 1'b0);
      end
      xbtm_pkg::OP_ERASE: begin
        if (32'(trie_cnt[leaf_at(v)]) < 32'(amt))
          o.status = xbtm_pkg::ST_UNDERFLOW;
        else
          walk_add(stored, amt, 1'b1);
      end
      xbtm_pkg::OP_COUNT: o.count = xbtm_pkg::RCNT_W'(trie_cnt[leaf_at(v)]);
      xbtm_pkg::OP_MAX, xbtm_pkg::OP_MIN: begin
        if (sz == 0)
          o.status = xbtm_pkg::ST_EMPTY;
        else
          o.value = xbtm_pkg::VAL_W'(extreme_of(op == xbtm_pkg::OP_MAX));
      end
      xbtm_pkg::OP_KTH: begin
        if (amt == '0 || 32'(amt) > sz)
          o.status = xbtm_pkg::ST_BAD_RANK;
        else
          o.value = xbtm_pkg::VAL_W'(rank_of(32'(amt)));
      end
      xbtm_pkg::OP_XOR: begin
        // an empty set keeps its mask
        if (sz != 0)
          trie_mask = trie_mask ^ v[VB-1:0];
      end
      default: o.count = xbtm_pkg::RCNT_W'(sz);
    endcase
    return o;
  endfunction

  initial begin
    foreach (trie_cnt[i])
      trie_cnt[i] = '0;
    trie_mask = '0;
  end

  // ---------------------------------------------------------------- drive and check

  task automatic send_item(logic [xbtm_pkg::OPC_W-1:0] op, logic [xbtm_pkg::VAL_W-1:0] v,
                           logic [xbtm_pkg::AMT_W-1:0] amt);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    opcode   <= op;
    value    <= v;
    amount   <= amt;
    // hold the beat until the core takes it
    do @(posedge clk); while (!in_ready);
    pending_q.push_back(apply_op(op, v, amt));
  endtask

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    mismatches++;
    if (mismatches <= PRINT_CAP)
      $display("[%0t] %s: got 0x%0h want 0x%0h", $time, what, got, want);
  endtask

  // Receiver stalls: spells of always ready, coin toss, and mostly stalled
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = $urandom_range(10, 60);
    end
    stall_left--;
    case (stall_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= 1'($urandom_range(0, 1));
      default: out_ready <= ($urandom_range(0, 4) == 0);
    endcase
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_q.size() == 0) begin
        report_mismatch("unexpected result beat", 32'(status), 0);
      end else begin
        due = pending_q.pop_front();
        if (result_value !== due.value)
          report_mismatch("result_value", 32'(result_value), 32'(due.value));
        if (result_count !== due.count)
          report_mismatch("result_count", 32'(result_count), 32'(due.count));
        if (status !== due.status)
          report_mismatch("status", 32'(status), 32'(due.status));
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_CAP) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------- tests

  task automatic test_empty_set();
    send_item(xbtm_pkg::OP_SIZE, 8'h00, 16'd0);
    send_item(xbtm_pkg::OP_MAX, 8'h00, 16'd0);
    send_item(xbtm_pkg::OP_MIN, 8'hFF, 16'd0);
    send_item(xbtm_pkg::OP_KTH, 8'h00, 16'd0);
    send_item(xbtm_pkg::OP_KTH, 8'h00, 16'd1);
    send_item(xbtm_pkg::OP_XOR, 8'h5A, 16'd0);
    send_item(xbtm_pkg::OP_ERASE, 8'h10, 16'd1);
    send_item(xbtm_pkg::OP_INSERT, 8'h33, 16'd0);
  endtask

  task automatic test_extremes();
    send_item(xbtm_pkg::OP_INSERT, 8'hFF, 16'hFFFF);
    send_item(xbtm_pkg::OP_INSERT, 8'h00, 16'd1);
    send_item(xbtm_pkg::OP_ERASE, 8'hFF, 16'hFFFF);
    send_item(xbtm_pkg::OP_INSERT, 8'h00, 16'd3);
    send_item(xbtm_pkg::OP_INSERT, 8'hFF, 16'd2);
    send_item(xbtm_pkg::OP_INSERT, 8'h80, 16'd1);
    send_item(xbtm_pkg::OP_ERASE, 8'h80, 16'd0);
    send_item(xbtm_pkg::OP_KTH, 8'h00, 16'd0);
    send_item(xbtm_pkg::OP_KTH, 8'h00, 16'd6);
    send_item(xbtm_pkg::OP_KTH, 8'h00, 16'd7);
    send_item(xbtm_pkg::OP_MIN, 8'h00, 16'd0);
    send_item(xbtm_pkg::OP_COUNT, 8'h00, 16'd0);
  endtask

  task automatic test_xor_mask();
    send_item(xbtm_pkg::OP_XOR, 8'hA5, 16'd0);
    send_item(xbtm_pkg::OP_MAX, 8'h00, 16'd0);
    send_item(xbtm_pkg::OP_MIN, 8'h00, 16'd0);
    send_item(xbtm_pkg::OP_KTH, 8'h00, 16'd4);
    send_item(xbtm_pkg::OP_SIZE, 8'h00, 16'd0);
  endtask

  task automatic test_random(int n_items);
    logic [xbtm_pkg::OPC_W-1:0] op;
    logic [xbtm_pkg::VAL_W-1:0] v;
    logic [xbtm_pkg::AMT_W-1:0] a;
    int unsigned                sz;
    int unsigned                lc;
    int                         pick;
    for (int i = 0; i < n_items; i++) begin
      // empty the set now and then so the empty-set cases come back
      if (i % 150 == 149) begin
        while (trie_cnt[xbtm_pkg::ROOT] != '0) begin
          v = xbtm_pkg::VAL_W'(rank_of(1));
          send_item(xbtm_pkg::OP_ERASE, v, xbtm_pkg::AMT_W'(trie_cnt[leaf_at(v)]));
        end
      end
      pick = $urandom_range(0, 99);
      sz   = 32'(trie_cnt[xbtm_pkg::ROOT]);
      v    = xbtm_pkg::VAL_W'($urandom_range(0, 255));
      a    = xbtm_pkg::AMT_W'($urandom_range(1, 20));
      if (pick < 30) begin
        op = xbtm_pkg::OP_INSERT;
        case ($urandom_range(0, 9))
          0:       a = xbtm_pkg::AMT_W'($urandom_range(0, 65535));
          1:       a = '0;
          2:       a = xbtm_pkg::AMT_W'(32'(xbtm_pkg::CNT_MAX) - sz + $urandom_range(0, 2));
          default: ;
        endcase
      end else if (pick < 50) begin
        op = xbtm_pkg::OP_ERASE;
        if (sz != 0 && $urandom_range(0, 9) < 7) begin
          v  = xbtm_pkg::VAL_W'(rank_of($urandom_range(1, sz)));
          lc = 32'(trie_cnt[leaf_at(v)]);
          a  = ($urandom_range(0, 2) == 0) ? xbtm_pkg::AMT_W'(lc)
                                           : xbtm_pkg::AMT_W'($urandom_range(1, lc));
        end else if ($urandom_range(0, 3) == 0) begin
          a = xbtm_pkg::AMT_W'($urandom_range(0, 65535));
        end
      end else if (pick < 60) begin
        op = xbtm_pkg::OP_COUNT;
        if (sz != 0 && $urandom_range(0, 1) == 0)
          v = xbtm_pkg::VAL_W'(rank_of($urandom_range(1, sz)));
      end else if (pick < 67) begin
        op = xbtm_pkg::OP_MAX;
      end else if (pick < 74) begin
        op = xbtm_pkg::OP_MIN;
      end else if (pick < 87) begin
        op = xbtm_pkg::OP_KTH;
        if (sz != 0 && $urandom_range(0, 9) < 8) begin
          a = xbtm_pkg::AMT_W'($urandom_range(1, sz));
        end else begin
          case ($urandom_range(0, 2))
            0:       a = '0;
            1:       a = xbtm_pkg::AMT_W'(sz + 1);
            default: a = xbtm_pkg::AMT_W'($urandom_range(0, 65535));
          endcase
        end
      end else if (pick < 93) begin
        op = xbtm_pkg::OP_XOR;
      end else begin
        op = xbtm_pkg::OP_SIZE;
      end
      send_item(op, v, a);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_empty_set();
    test_extremes();
    test_xor_mask();
    test_random(600);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_TIME) @(posedge clk);
    if (mismatches == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

>>> xor_binary_trie_multiset_core.f
sv/xbtm_pkg.sv
sv/xbtm_ram.sv
sv/xbtm_ctrl.sv
sv/xor_binary_trie_multiset_core.sv
sv/xbtm_chk.sv
tb/xor_binary_trie_multiset_core_tb.sv
